// File: rtl/assert_macros.svh
// Assertion helpers; each use expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// File: rtl/rirc_pkg.sv
package rirc_pkg;

  localparam int HEADER_BYTES = 9;
  localparam logic [7:0] FUNC_READ_INPUTS = 8'h02;
  localparam logic [8:0] POS_MAX = 9'd511;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_TRANSACTION = 3'd2,
    ST_PROTOCOL    = 3'd3,
    ST_UNIT        = 3'd4,
    ST_FUNCTION    = 3'd5,
    ST_COUNT       = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_TRANSACTION = 2'd0,
    REG_UNIT        = 2'd1,
    REG_BITS        = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [2:0] status;
    logic       last;
  } result_t;

endpackage

// File: rtl/rirc_rx_if.sv
interface rirc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

// File: rtl/rirc_res_if.sv
interface rirc_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output result_kind, output payload_byte,
                  output payload_index, output status, output last, input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input payload_index, input status, input last, output ready);
endinterface

// File: rtl/read_inputs_response_checker_core.sv
// Response checker for a read-discrete-inputs frame, one byte per item.
// rx: valid/ready channel of frame bytes; frame_end marks the last byte.
// res: valid/ready channel of results. Each byte from position 9 on gives a
//   provisional payload result; the last byte of a frame also gives a final
//   status result (after the payload result when both occur).
// cfg: write enable, register index and 16-bit data; write only while idle.
// Each result is registered into the result queue when its byte is accepted.
// Throughput: one byte per cycle while results are taken as fast as they are
//   made; a byte that yields two results queues both, and they leave one by one. The limit is
//   the single result port draining a four-entry result queue.
// rx.ready is high while the queue has room for two results, so a byte is
//   still accepted while earlier results wait on a stalled receiver; once
//   fewer than two entries are free, rx.ready drops until results are taken.
// Reset (rst, synchronous) empties the queue, restarts the frame and loads
//   the register defaults (expected bits 1, others 0).
module read_inputs_response_checker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  rirc_rx_if.sink     rx,
  rirc_res_if.source  res
);

`include "assert_macros.svh"

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [15:0] expected_transaction;
  logic [7:0]  expected_unit;
  logic [10:0] expected_bits;

  logic [8:0] byte_position;
  logic [2:0] first_error;
  logic [7:0] declared_count;

  logic [8:0] byte_position_next;
  logic [2:0] first_error_next;
  logic [7:0] declared_count_next;

  rirc_pkg::result_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic rx_acc;
  logic res_acc;
  logic has_pay;
  logic [2:0] err_here;
  logic [8:0] length;
  logic [8:0] want_len;
  logic [2:0] final_status;
  logic [8:0] idx_full;
  rirc_pkg::result_t pay_res;
  rirc_pkg::result_t fin_res;
  rirc_pkg::result_t head;
  logic [1:0] n_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_transaction <= 16'd0;
      expected_unit <= 8'd0;
      expected_bits <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        rirc_pkg::REG_TRANSACTION: expected_transaction <= cfg_data;
        rirc_pkg::REG_UNIT: expected_unit <= cfg_data[7:0];
        rirc_pkg::REG_BITS: expected_bits <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign rx_acc = rx.valid && rx.ready;
  assign res_acc = res.valid && res.ready;
  assign rx.ready = (count <= CW'(DEPTH - 2));

  always_comb begin
    err_here = rirc_pkg::ST_OK;
    declared_count_next = declared_count;
    case (byte_position)
      9'd0: if (rx.rx_byte != expected_transaction[15:8]) err_here = rirc_pkg::ST_TRANSACTION;
      9'd1: if (rx.rx_byte != expected_transaction[7:0]) err_here = rirc_pkg::ST_TRANSACTION;
      9'd2, 9'd3: if (rx.rx_byte != 8'd0) err_here = rirc_pkg::ST_PROTOCOL;
      9'd6: if (rx.rx_byte != expected_unit) err_here = rirc_pkg::ST_UNIT;
      9'd7: if (rx.rx_byte != rirc_pkg::FUNC_READ_INPUTS) err_here = rirc_pkg::ST_FUNCTION;
      9'd8: begin
        declared_count_next = rx.rx_byte;
        if (rx.rx_byte == 8'd0 || {rx.rx_byte, 3'b000} < expected_bits) begin
          err_here = rirc_pkg::ST_COUNT;
        end
      end
      default: ;
    endcase
    first_error_next = (first_error != rirc_pkg::ST_OK) ? first_error : err_here;
    byte_position_next = (byte_position < rirc_pkg::POS_MAX) ?
                         byte_position + 9'd1 : byte_position;

    has_pay = (byte_position >= 9'(rirc_pkg::HEADER_BYTES));
    idx_full = byte_position - 9'(rirc_pkg::HEADER_BYTES);
    pay_res.result_kind = 1'b0;
    pay_res.payload_byte = rx.rx_byte;
    pay_res.payload_index = idx_full[8] ? 8'd255 : idx_full[7:0];
    pay_res.status = rirc_pkg::ST_OK;
    pay_res.last = 1'b0;

    length = byte_position_next;
    want_len = 9'(rirc_pkg::HEADER_BYTES) + {1'b0, declared_count_next};
    if (length < 9'(rirc_pkg::HEADER_BYTES)) final_status = rirc_pkg::ST_SHORT;
    else if (first_error_next != rirc_pkg::ST_OK) final_status = first_error_next;
    else if (length != want_len) final_status = rirc_pkg::ST_SHORT;
    else final_status = rirc_pkg::ST_OK;
    fin_res.result_kind = 1'b1;
    fin_res.payload_byte = 8'd0;
    fin_res.payload_index = 8'd0;
    fin_res.status = final_status;
    fin_res.last = 1'b1;

    n_push = rx_acc ? ({1'b0, has_pay} + {1'b0, rx.frame_end}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 9'd0;
      first_error <= rirc_pkg::ST_OK;
      declared_count <= 8'd0;
    end else if (rx_acc) begin
      if (rx.frame_end) begin
        byte_position <= 9'd0;
        first_error <= rirc_pkg::ST_OK;
        declared_count <= 8'd0;
      end else begin
        byte_position <= byte_position_next;
        first_error <= first_error_next;
        declared_count <= declared_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= has_pay ? pay_res : fin_res;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= fin_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(n_push);
      if (res_acc) rd_ptr <= rd_ptr + PW'(1);
      count <= count + CW'(n_push) - CW'(res_acc);
    end
  end

  assign head = mem[rd_ptr];
  assign res.valid = (count != '0);
  assign res.result_kind = head.result_kind;
  assign res.payload_byte = head.payload_byte;
  assign res.payload_index = head.payload_index;
  assign res.status = head.status;
  assign res.last = head.last;

  `ASSERT_ALWAYS(a_queue_bound, count <= CW'(DEPTH))
  `ASSERT_NEXT(a_frame_restart, rx_acc && rx.frame_end,
               byte_position == 9'd0 && first_error == rirc_pkg::ST_OK)
  `ASSERT_NEXT(a_pos_saturate, rx_acc && !rx.frame_end && byte_position == rirc_pkg::POS_MAX,
               byte_position == rirc_pkg::POS_MAX)
  `ASSERT_IMPLIES(a_last_is_final, res.valid && res.last, res.result_kind)

endmodule

// File: test/read_inputs_response_checker_core_tb.sv
module read_inputs_response_checker_core_tb;

  localparam int ITEM_TARGET = 1050;
  localparam int PHASE_ITEMS = 160;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  class frame_verdict_tracker;
    logic [15:0]       tid;
    logic [7:0]        unit_id;
    logic [10:0]       bit_need;
    logic [8:0]        position;
    rirc_pkg::status_t first_err;
    logic [7:0]        count;
    rirc_pkg::result_t awaited_results[$];
    int                errors;

    function new();
      tid = '0;
      unit_id = '0;
      bit_need = 11'd1;
      position = '0;
      first_err = rirc_pkg::ST_OK;
      count = '0;
      errors = 0;
    endfunction

    function void set_reg(rirc_pkg::reg_index_t idx, logic [15:0] value);
      case (idx)
        rirc_pkg::REG_TRANSACTION: tid = value;
        rirc_pkg::REG_UNIT: unit_id = value[7:0];
        rirc_pkg::REG_BITS: bit_need = value[10:0];
        default: ;
      endcase
    endfunction

    function void flag(rirc_pkg::status_t code);
      if (first_err == rirc_pkg::ST_OK) first_err = code;
    endfunction

    function void note_byte(logic [7:0] b, logic fe);
      rirc_pkg::result_t r;
      int idx;
      rirc_pkg::status_t st;
      case (position)
        0: if (b != tid[15:8]) flag(rirc_pkg::ST_TRANSACTION);
        1: if (b != tid[7:0]) flag(rirc_pkg::ST_TRANSACTION);
        2, 3: if (b != 8'd0) flag(rirc_pkg::ST_PROTOCOL);
        6: if (b != unit_id) flag(rirc_pkg::ST_UNIT);
        7: if (b != rirc_pkg::FUNC_READ_INPUTS) flag(rirc_pkg::ST_FUNCTION);
        8: begin
          count = b;
          if (b == 8'd0 || int'(b) * 8 < int'(bit_need)) flag(rirc_pkg::ST_COUNT);
        end
        default: ;
      endcase
      if (int'(position) >= rirc_pkg::HEADER_BYTES) begin
        idx = int'(position) - rirc_pkg::HEADER_BYTES;
        if (idx > 255) idx = 255;
        r.result_kind = 1'b0;
        r.payload_byte = b;
        r.payload_index = idx[7:0];
        r.status = rirc_pkg::ST_OK;
        r.last = 1'b0;
        awaited_results.push_back(r);
      end
      if (position < rirc_pkg::POS_MAX) position = position + 9'd1;
      if (fe) begin
        if (int'(position) < rirc_pkg::HEADER_BYTES) st = rirc_pkg::ST_SHORT;
        else if (first_err != rirc_pkg::ST_OK) st = first_err;
        else if (int'(position) != rirc_pkg::HEADER_BYTES + int'(count))
          st = rirc_pkg::ST_SHORT;
        else st = rirc_pkg::ST_OK;
        r.result_kind = 1'b1;
        r.payload_byte = '0;
        r.payload_index = '0;
        r.status = st;
        r.last = 1'b1;
        awaited_results.push_back(r);
        position = '0;
        first_err = rirc_pkg::ST_OK;
        count = '0;
      end
    endfunction

    function void check_result(rirc_pkg::result_t got);
      rirc_pkg::result_t want;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d byte %0d index %0d status %0d last %0d",
               got.result_kind, got.payload_byte, got.payload_index, got.status, got.last);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
        errors++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0d, got %0d", want.payload_byte, got.payload_byte);
        errors++;
      end
      if (got.payload_index !== want.payload_index) begin
        $error("payload_index: expected %0d, got %0d", want.payload_index, got.payload_index);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  rirc_rx_if  rx_ch();
  rirc_res_if res_ch();

  read_inputs_response_checker_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .rx(rx_ch.sink),
    .res(res_ch.source)
  );

  frame_verdict_tracker board = new();
  logic [7:0] frame_bytes[$];
  int items_sent;
  int tx_quiet;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    rx_ch.frame_end = 1'b0;
    res_ch.ready = 1'b0;
    items_sent = 0;
    tx_quiet = 0;
    idle_cycles = 0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic fe);
    int gap;
    if (items_sent % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    rx_ch.frame_end <= fe;
    do @(posedge clk); while (!(rx_ch.valid && rx_ch.ready));
    board.note_byte(b, fe);
    items_sent++;
  endtask

  task automatic send_frame(output int sent);
    sent = frame_bytes.size();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic program_regs(logic [15:0] tid, logic [7:0] unit_id, logic [10:0] bit_need);
    cfg_we <= 1'b1;
    cfg_index <= rirc_pkg::REG_TRANSACTION;
    cfg_data <= tid;
    @(posedge clk);
    board.set_reg(rirc_pkg::REG_TRANSACTION, tid);
    cfg_index <= rirc_pkg::REG_UNIT;
    cfg_data <= {8'd0, unit_id};
    @(posedge clk);
    board.set_reg(rirc_pkg::REG_UNIT, {8'd0, unit_id});
    cfg_index <= rirc_pkg::REG_BITS;
    cfg_data <= {5'd0, bit_need};
    @(posedge clk);
    board.set_reg(rirc_pkg::REG_BITS, {5'd0, bit_need});
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // kind: 0 well-formed, 1 defective, 2 noise, 3 oversized
  task automatic make_frame(int kind);
    logic [7:0] h[9];
    int need, paylen, cut, defects;
    need = (int'(board.bit_need) + 7) / 8;
    if (need < 1) need = 1;
    h[0] = board.tid[15:8];
    h[1] = board.tid[7:0];
    h[2] = 8'd0;
    h[3] = 8'd0;
    h[4] = 8'($urandom_range(0, 255));
    h[5] = 8'($urandom_range(0, 255));
    h[6] = board.unit_id;
    h[7] = rirc_pkg::FUNC_READ_INPUTS;
    paylen = need + $urandom_range(0, 3);
    if (paylen > 255) paylen = 255;
    h[8] = 8'(paylen);
    cut = 0;
    frame_bytes.delete();
    if (kind == 2) begin
      repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (kind == 3) begin
      h[8] = 8'd255;
      paylen = 511;
    end
    if (kind == 1) begin
      defects = ($urandom_range(0, 3) == 0) ? 2 : 1;
      repeat (defects) begin
        case ($urandom_range(0, 10))
          0: h[0] ^= 8'($urandom_range(1, 255));
          1: h[1] ^= 8'($urandom_range(1, 255));
          2: h[2] = 8'($urandom_range(1, 255));
          3: h[3] = 8'($urandom_range(1, 255));
          4: h[6] ^= 8'($urandom_range(1, 255));
          5: h[7] = rirc_pkg::FUNC_READ_INPUTS ^ 8'($urandom_range(1, 255));
          6: begin
            h[8] = 8'd0;
            paylen = 0;
          end
          7: begin
            if (need > 1) begin
              h[8] = 8'($urandom_range(1, need - 1));
              paylen = h[8];
            end else begin
              paylen++;
            end
          end
          8: paylen = paylen + $urandom_range(1, 3);
          9: if (paylen > 0) paylen = $urandom_range(0, paylen - 1);
          default: cut = $urandom_range(1, 8);
        endcase
      end
    end
    for (int i = 0; i < 9; i++) frame_bytes.push_back(h[i]);
    repeat (paylen) frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (cut > 0) while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
  endtask

  initial begin : results_side
    int stall;
    int taken;
    int quiet;
    rirc_pkg::result_t got;
    taken = 0;
    quiet = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (taken == 150 || taken == 450) stall = HOLD_CYCLES;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      got.result_kind = res_ch.result_kind;
      got.payload_byte = res_ch.payload_byte;
      got.payload_index = res_ch.payload_index;
      got.status = res_ch.status;
      got.last = res_ch.last;
      board.check_result(got);
      taken++;
    end
  end

  initial begin : bytes_side
    int phase, phase_items, sent, pick;
    logic [15:0] tid;
    logic [7:0] unit_id;
    logic [10:0] bit_need;
    bit long_done;
    phase = 0;
    long_done = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    frame_bytes = '{8'hFF};
    send_frame(sent);
    frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h02, 8'h01, 8'hA5};
    send_frame(sent);
    frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h02, 8'h00};
    send_frame(sent);
    frame_bytes = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02};
    send_frame(sent);
    settle();

    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: begin
          tid = 16'hFFFF;
          unit_id = 8'hFF;
          bit_need = 11'd2040;
        end
        1: begin
          tid = 16'h0000;
          unit_id = 8'h00;
          bit_need = 11'd0;
        end
        default: begin
          tid = 16'($urandom_range(0, 65535));
          unit_id = 8'($urandom_range(0, 255));
          bit_need = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2040))
                                                  : 11'($urandom_range(0, 96));
        end
      endcase
      program_regs(tid, unit_id, bit_need);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
        pick = $urandom_range(0, 19);
        if (phase == 2 && !long_done) begin
          make_frame(3);
          long_done = 1'b1;
        end else begin
          make_frame(pick < 10 ? 0 : (pick < 17 ? 1 : 2));
        end
        send_frame(sent);
        phase_items += sent;
      end
      settle();
      phase++;
    end

    repeat (5) @(posedge clk);
    if (board.errors == 0 && board.awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
